FILE: rtl/sbe_pkg.sv
// shared types, opcodes and constants of the stack bytecode executor
`default_nettype none
package sbe_pkg;
    localparam int MEM_WORDS_DEF  = 16384;
    localparam int TEXT_WORDS_DEF = 16384;
    localparam int PC_W   = 14;
    localparam int SP_W   = 16;
    localparam int DATA_W = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [PC_W-1:0] START_PC_RST  = 14'd0;
    localparam logic [SP_W-1:0] STACK_TOP_RST = 16'd65532;

    localparam logic [CFG_IDX_W-1:0] REG_START_PC  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STACK_TOP = 1'b1;

    typedef enum logic [5:0] {
        OP_LEA = 6'd0, OP_IMM = 6'd1, OP_JMP = 6'd2, OP_CALL = 6'd3, OP_JZ = 6'd4,
        OP_JNZ = 6'd5, OP_ENT = 6'd6, OP_ADJ = 6'd7, OP_LEV = 6'd8, OP_LI = 6'd9,
        OP_LC = 6'd10, OP_SI = 6'd11, OP_SC = 6'd12, OP_PUSH = 6'd13, OP_OR = 6'd14,
        OP_XOR = 6'd15, OP_AND = 6'd16, OP_EQ = 6'd17, OP_NE = 6'd18, OP_LT = 6'd19,
        OP_GT = 6'd20, OP_LE = 6'd21, OP_GE = 6'd22, OP_SHL = 6'd23, OP_SHR = 6'd24,
        OP_ADD = 6'd25, OP_SUB = 6'd26, OP_MUL = 6'd27, OP_DIV = 6'd28, OP_MOD = 6'd29,
        OP_EXIT = 6'd37
    } opcode_t;

    typedef enum logic [1:0] {
        ST_RUN = 2'd0, ST_EXITED = 2'd1, ST_BADOP = 2'd2, ST_DIVZERO = 2'd3
    } status_t;

    // controller -> datapath commands
    typedef struct packed {
        logic take;       // latch request
        logic rd_sp;      // read word at sp
        logic rd_fp;      // read word at fp (LEV first pop)
        logic rd_fp4;     // read word at fp+4
        logic rd_acc;     // read word at acc
        logic rd_a;       // read word at popped address
        logic lev1;       // LEV: capture new fp from read data
        logic grab_l;     // capture read data as left operand / address
        logic div_start;
        logic exec;       // commit the instruction
        logic cfg_we;
    } sbe_cmd_t;

    typedef struct packed {
        logic div_done;
        logic halted;
    } sbe_sts_t;
endpackage
`default_nettype wire

FILE: rtl/stack_bytecode_executor.sv
// stack bytecode executor top level
//  channel | direction | handshake              | payload
//  s_      | in        | s_valid / s_ready      | s_operation, s_immediate
//  m_      | out       | m_valid / m_ready      | m_next_pc .. m_exit_value
//  cfg_    | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
// a request steps through read states, more for pops and frame return; div and mod
// also wait on the bit-serial divider. The stack memory's single read port sets the reads.
// synchronous active-low reset; stack memory is not cleared.
// a waiting result holds off the next request until m_ready takes it.
`default_nettype none
module stack_bytecode_executor #(
    parameter int MEM_WORDS  = sbe_pkg::MEM_WORDS_DEF,
    parameter int TEXT_WORDS = sbe_pkg::TEXT_WORDS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [5:0]                    s_operation,
    input  wire logic signed [31:0]            s_immediate,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [sbe_pkg::PC_W-1:0]           m_next_pc,
    output logic signed [31:0]                 m_acc_value,
    output logic [sbe_pkg::SP_W-1:0]           m_stack_addr,
    output logic [1:0]                         m_status,
    output logic signed [31:0]                 m_exit_value,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [sbe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data
);
    import sbe_pkg::*;
    sbe_cmd_t cmd;
    sbe_sts_t sts;

    sbe_controller u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_operation(s_operation), .m_valid(m_valid), .m_ready(m_ready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cmd(cmd), .sts(sts)
    );

    sbe_datapath #(.MEM_WORDS(MEM_WORDS), .TEXT_WORDS(TEXT_WORDS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .s_operation(s_operation), .s_immediate(s_immediate),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .r_next_pc(m_next_pc), .r_acc_value(m_acc_value),
        .r_stack_addr(m_stack_addr), .r_status(m_status), .r_exit_value(m_exit_value)
    );
endmodule
`default_nettype wire

FILE: rtl/sbe_divider.sv
// iterative 32-bit unsigned divider, one quotient bit a cycle
`default_nettype none
module sbe_divider (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quotient,
    output logic [31:0]      remainder
);
    logic [31:0] q_reg, q_next, r_reg, r_next, d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [32:0] trial;

    always_comb begin
        q_next = q_reg; r_next = r_reg; d_next = d_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        trial = {r_reg, q_reg[31]} - {1'b0, d_reg};
        if (start) begin
            q_next = dividend; r_next = '0; d_next = divisor;
            cnt_next = 6'd32; busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[32]) begin
                r_next = trial[31:0];
                q_next = {q_reg[30:0], 1'b1};
            end else begin
                r_next = {r_reg[30:0], q_reg[31]};
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;
endmodule
`default_nettype wire

FILE: rtl/sbe_datapath.sv
// architectural registers, stack memory and alu of the executor
`default_nettype none
module sbe_datapath #(
    parameter int MEM_WORDS  = sbe_pkg::MEM_WORDS_DEF,
    parameter int TEXT_WORDS = sbe_pkg::TEXT_WORDS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire sbe_pkg::sbe_cmd_t             cmd,
    output sbe_pkg::sbe_sts_t                  sts,
    input  wire logic [5:0]                    s_operation,
    input  wire logic signed [31:0]            s_immediate,
    input  wire logic [sbe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data,
    output logic [sbe_pkg::PC_W-1:0]           r_next_pc,
    output logic signed [31:0]                 r_acc_value,
    output logic [sbe_pkg::SP_W-1:0]           r_stack_addr,
    output logic [1:0]                         r_status,
    output logic signed [31:0]                 r_exit_value
);
    import sbe_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);

    logic [31:0] mem [MEM_WORDS];
    logic [31:0] rdata_reg;
    logic [AW-1:0] raddr;
    logic        mem_we;
    logic [AW-1:0] waddr;
    logic [31:0] wdata;

    logic [31:0] acc_reg, acc_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic [SP_W-1:0] sp_reg, sp_next, fp_reg, fp_next;
    logic [1:0]  hcode_reg, hcode_next;
    logic        halted_reg, halted_next;
    logic [5:0]  op_reg;
    logic [31:0] imm_reg, l_reg, newfp_reg;
    logic [1:0]  status_c;
    logic [31:0] exitv_c;
    logic [31:0] alu_c;
    logic        div_done;
    logic [31:0] quo, rem;

    function automatic logic [31:0] tw(input logic [31:0] x);
        logic [31:0] m;
        m = x & 32'(TEXT_WORDS - 1);
        return m & 32'h3FFF;
    endfunction

    function automatic logic [AW-1:0] wa(input logic [31:0] a);
        return a[AW+1:2];
    endfunction

    function automatic logic [31:0] sx8(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

    // read address mux
    always_comb begin
        raddr = wa(32'(sp_reg));
        if (cmd.rd_fp)       raddr = wa(32'(fp_reg));
        else if (cmd.rd_fp4) raddr = wa(32'(fp_reg) + 32'd4);
        else if (cmd.rd_acc) raddr = wa(acc_reg);
        else if (cmd.rd_a)   raddr = wa(l_reg);
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
        if (mem_we) mem[waddr] <= wdata;
    end

    sbe_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .dividend(l_reg[31] ? (32'd0 - l_reg) : l_reg),
        .divisor(acc_reg[31] ? (32'd0 - acc_reg) : acc_reg),
        .done(div_done), .quotient(quo), .remainder(rem)
    );

    // alu, left operand l_reg, right operand accumulator
    always_comb begin
        alu_c = '0;
        case (op_reg)
            OP_OR:  alu_c = l_reg | acc_reg;
            OP_XOR: alu_c = l_reg ^ acc_reg;
            OP_AND: alu_c = l_reg & acc_reg;
            OP_EQ:  alu_c = 32'(l_reg == acc_reg);
            OP_NE:  alu_c = 32'(l_reg != acc_reg);
            OP_LT:  alu_c = 32'($signed(l_reg) < $signed(acc_reg));
            OP_GT:  alu_c = 32'($signed(l_reg) > $signed(acc_reg));
            OP_LE:  alu_c = 32'($signed(l_reg) <= $signed(acc_reg));
            OP_GE:  alu_c = 32'($signed(l_reg) >= $signed(acc_reg));
            OP_SHL: alu_c = (acc_reg >= 32'd32) ? 32'd0 : (l_reg << acc_reg[4:0]);
            OP_SHR: alu_c = (acc_reg >= 32'd32) ? {32{l_reg[31]}}
                                                : 32'($signed(l_reg) >>> acc_reg[4:0]);
            OP_ADD: alu_c = l_reg + acc_reg;
            OP_SUB: alu_c = l_reg - acc_reg;
            OP_MUL: alu_c = l_reg * acc_reg;
            OP_DIV: alu_c = (l_reg[31] != acc_reg[31]) ? (32'd0 - quo) : quo;
            OP_MOD: alu_c = l_reg[31] ? (32'd0 - rem) : rem;
            default: alu_c = '0;
        endcase
    end

    always_comb begin
        logic [31:0] pc2, pc1, jt, t;
        logic [4:0]  sh;
        pc2 = tw(32'(pc_reg) + 32'd2);
        pc1 = tw(32'(pc_reg) + 32'd1);
        jt  = tw(imm_reg);
        sh  = {acc_reg[1:0], 3'b000};
        acc_next = acc_reg; pc_next = pc_reg; sp_next = sp_reg; fp_next = fp_reg;
        hcode_next = hcode_reg; halted_next = halted_reg;
        mem_we = 1'b0; waddr = wa(32'(sp_reg)); wdata = '0;
        status_c = ST_RUN; exitv_c = '0;
        t = rdata_reg;
        if (cmd.cfg_we) begin
            if (cfg_index == REG_START_PC) pc_next = cfg_data[PC_W-1:0];
            else begin
                sp_next = cfg_data[SP_W-1:0];
                fp_next = cfg_data[SP_W-1:0];
            end
        end else if (cmd.exec) begin
            if (halted_reg) begin
                status_c = hcode_reg;
                if (hcode_reg == ST_EXITED) exitv_c = rdata_reg;
            end else begin
                case (op_reg)
                    OP_LEA: begin
                        acc_next = 32'(fp_reg) + (imm_reg << 2);
                        pc_next = pc2[PC_W-1:0];
                    end
                    OP_IMM: begin acc_next = imm_reg; pc_next = pc2[PC_W-1:0]; end
                    OP_JMP: pc_next = jt[PC_W-1:0];
                    OP_CALL: begin
                        sp_next = sp_reg - 16'd4;
                        mem_we = 1'b1; waddr = wa(32'(sp_next)); wdata = pc2;
                        pc_next = jt[PC_W-1:0];
                    end
                    OP_JZ:  pc_next = (acc_reg != 0) ? pc2[PC_W-1:0] : jt[PC_W-1:0];
                    OP_JNZ: pc_next = (acc_reg != 0) ? jt[PC_W-1:0] : pc2[PC_W-1:0];
                    OP_ENT: begin
                        mem_we = 1'b1; waddr = wa(32'(sp_reg - 16'd4));
                        wdata = 32'(fp_reg);
                        fp_next = sp_reg - 16'd4;
                        sp_next = fp_next - {imm_reg[13:0], 2'b00};
                        pc_next = pc2[PC_W-1:0];
                    end
                    OP_ADJ: begin
                        sp_next = sp_reg + {imm_reg[13:0], 2'b00};
                        pc_next = pc2[PC_W-1:0];
                    end
                    OP_LEV: begin
                        fp_next = newfp_reg[SP_W-1:0];
                        sp_next = fp_reg + 16'd8;
                        t = tw(rdata_reg);
                        pc_next = t[PC_W-1:0];
                    end
                    OP_LI: begin acc_next = rdata_reg; pc_next = pc1[PC_W-1:0]; end
                    OP_LC: begin
                        acc_next = sx8(8'(rdata_reg >> sh));
                        pc_next = pc1[PC_W-1:0];
                    end
                    OP_SI: begin
                        mem_we = 1'b1; waddr = wa(l_reg); wdata = acc_reg;
                        sp_next = sp_reg + 16'd4; pc_next = pc1[PC_W-1:0];
                    end
                    OP_SC: begin
                        sh = {l_reg[1:0], 3'b000};
                        t = rdata_reg & ~(32'hFF << sh);
                        t = t | ({24'd0, acc_reg[7:0]} << sh);
                        mem_we = 1'b1; waddr = wa(l_reg); wdata = t;
                        acc_next = sx8(acc_reg[7:0]);
                        sp_next = sp_reg + 16'd4; pc_next = pc1[PC_W-1:0];
                    end
                    OP_PUSH: begin
                        sp_next = sp_reg - 16'd4;
                        mem_we = 1'b1; waddr = wa(32'(sp_next)); wdata = acc_reg;
                        pc_next = pc1[PC_W-1:0];
                    end
                    OP_EXIT: begin
                        exitv_c = rdata_reg; status_c = ST_EXITED;
                        halted_next = 1'b1; hcode_next = ST_EXITED;
                        pc_next = pc1[PC_W-1:0];
                    end
                    default: begin
                        if (op_reg >= OP_OR && op_reg <= OP_MOD) begin
                            if ((op_reg == OP_DIV || op_reg == OP_MOD) && acc_reg == 0) begin
                                status_c = ST_DIVZERO;
                                halted_next = 1'b1; hcode_next = ST_DIVZERO;
                            end else begin
                                acc_next = alu_c;
                                sp_next = sp_reg + 16'd4;
                                pc_next = pc1[PC_W-1:0];
                            end
                        end else begin
                            status_c = ST_BADOP;
                            halted_next = 1'b1; hcode_next = ST_BADOP;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0; pc_reg <= START_PC_RST;
            sp_reg <= STACK_TOP_RST; fp_reg <= STACK_TOP_RST;
            halted_reg <= 1'b0; hcode_reg <= ST_RUN;
        end else begin
            acc_reg <= acc_next; pc_reg <= pc_next; sp_reg <= sp_next; fp_reg <= fp_next;
            halted_reg <= halted_next; hcode_reg <= hcode_next;
        end
        if (cmd.take) begin
            op_reg  <= s_operation;
            imm_reg <= s_immediate;
        end
        if (cmd.grab_l) l_reg <= rdata_reg;
        if (cmd.lev1) newfp_reg <= rdata_reg;
        if (cmd.exec) begin
            r_next_pc    <= pc_next;
            r_acc_value  <= acc_next;
            r_stack_addr <= sp_next;
            r_status     <= status_c;
            r_exit_value <= exitv_c;
        end
    end

    assign sts.div_done = div_done;
    assign sts.halted   = halted_reg;
endmodule
`default_nettype wire

FILE: rtl/sbe_controller.sv
// sequencing state machine of the executor
`default_nettype none
module sbe_controller (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [5:0]        s_operation,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    output sbe_pkg::sbe_cmd_t      cmd,
    input  wire sbe_pkg::sbe_sts_t sts
);
    import sbe_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001, S_RD1 = 8'b00000010, S_RD2 = 8'b00000100,
        S_RD3  = 8'b00001000, S_DIV = 8'b00010000, S_EXEC = 8'b00100000,
        S_OUT  = 8'b01000000, S_LEV2 = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [5:0] op_reg;
    logic mv_reg, mv_next;
    logic needs_pop, is_div;

    assign needs_pop = (op_reg >= OP_OR && op_reg <= OP_MOD) || op_reg == OP_SI ||
                       op_reg == OP_SC;
    assign is_div = op_reg == OP_DIV || op_reg == OP_MOD;

    assign s_ready   = (state_reg == S_IDLE) && !cfg_valid && (!mv_reg || m_ready);
    assign cfg_ready = (state_reg == S_IDLE) && !mv_reg;
    assign m_valid   = mv_reg;

    always_comb begin
        state_next = state_reg;
        mv_next = mv_reg && !m_ready;
        cmd = '0;
        cmd.cfg_we = cfg_valid && cfg_ready;
        case (state_reg)
            S_IDLE: if (s_valid && s_ready) begin
                cmd.take = 1'b1;
                state_next = S_RD1;
            end
            S_RD1: begin
                // first read: sp, or fp for a frame return, or acc for loads
                if (sts.halted) cmd.rd_sp = 1'b1;
                else if (op_reg == OP_LEV) cmd.rd_fp = 1'b1;
                else if (op_reg == OP_LI || op_reg == OP_LC) cmd.rd_acc = 1'b1;
                else cmd.rd_sp = 1'b1;
                state_next = (!sts.halted && (needs_pop || op_reg == OP_LEV)) ? S_RD2 : S_EXEC;
            end
            S_RD2: begin
                if (op_reg == OP_LEV) begin
                    cmd.lev1 = 1'b1; cmd.rd_fp4 = 1'b1;
                    state_next = S_LEV2;
                end else begin
                    cmd.grab_l = 1'b1;
                    state_next = S_RD3;
                end
            end
            // keep the return pc word on the read port for the commit
            S_LEV2: begin
                cmd.rd_fp4 = 1'b1;
                state_next = S_EXEC;
            end
            S_RD3: begin
                cmd.rd_a = 1'b1;
                if (is_div) begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end else state_next = S_EXEC;
            end
            S_DIV: if (sts.div_done) state_next = S_EXEC;
            S_EXEC: begin
                cmd.rd_a = needs_pop && !sts.halted;
                cmd.exec = 1'b1;
                mv_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg <= mv_next;
        end
        if (cmd.take) op_reg <= s_operation;
    end
endmodule
`default_nettype wire

FILE: rtl/sbe_checker.sv
// port-level checks of the executor, bound to the top level
`default_nettype none
module sbe_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_status,
    input wire logic [31:0] m_exit_value,
    input wire logic        cfg_ready
);
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("back-to-back requests");
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_status)) else $error("result dropped");
    a_exit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != 2'd1) |-> m_exit_value == 32'd0) else $error("stray exit");
    a_cfg_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready |-> !m_valid) else $error("cfg while busy");
endmodule

bind stack_bytecode_executor sbe_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_exit_value(m_exit_value), .cfg_ready(cfg_ready)
);
`default_nettype wire

FILE: tb/sv/stack_bytecode_executor_tb.sv
// testbench for the stack bytecode executor: predicted results checked on every request
`timescale 1ns / 1ps
module stack_bytecode_executor_tb;
    import sbe_pkg::*;

    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic [5:0]  op;
        logic [31:0] imm;
    } instr_t;

    typedef struct packed {
        logic [13:0] pc;
        logic [31:0] acc;
        logic [15:0] sp;
        logic [1:0]  status;
        logic [31:0] exitv;
    } vm_state_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [5:0]  s_operation = '0;
    logic signed [31:0] s_immediate = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [PC_W-1:0] m_next_pc;
    logic signed [31:0] m_acc_value;
    logic [SP_W-1:0] m_stack_addr;
    logic [1:0]  m_status;
    logic signed [31:0] m_exit_value;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    stack_bytecode_executor dut (.*);

    // predicted machine state
    logic [13:0] vm_start_pc, vm_pc;
    logic [15:0] vm_stack_top, vm_sp, vm_fp;
    logic [31:0] vm_acc;
    logic        vm_halted;
    logic [1:0]  vm_code;
    logic [31:0] vm_mem [16384];
    bit          vm_written [16384];
    int          written_words [$];

    instr_t        pending_instrs [$];
    vm_state_out_t expected_states [$];

    int errors = 0;
    int s_idle_pct = 0, m_idle_pct = 0;
    bit hold_req = 0, hold_seen = 0;
    int hold_cnt = 0;
    int quiet_cycles = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic [31:0] mem_rd(input logic [31:0] addr);
        return vm_mem[addr[15:2]];
    endfunction

    function automatic bit is_written(input logic [31:0] addr);
        return vm_written[addr[15:2]];
    endfunction

    task automatic mem_wr(input logic [31:0] addr, input logic [31:0] v);
        vm_mem[addr[15:2]] = v;
        if (!vm_written[addr[15:2]]) begin
            vm_written[addr[15:2]] = 1;
            written_words.push_back(addr[15:2]);
        end
    endtask

    task automatic push_word(input logic [31:0] v);
        vm_sp = vm_sp - 16'd4;
        mem_wr({16'd0, vm_sp}, v);
    endtask

    task automatic pop_word(output logic [31:0] v);
        v = mem_rd({16'd0, vm_sp});
        vm_sp = vm_sp + 16'd4;
    endtask

    function automatic logic [31:0] sext8(input logic [31:0] b);
        return {{24{b[7]}}, b[7:0]};
    endfunction

    function automatic logic [31:0] mag(input logic [31:0] u);
        return u[31] ? (32'd0 - u) : u;
    endfunction

    function automatic logic [31:0] alu_calc(input logic [5:0] op, input logic [31:0] l,
                                             input logic [31:0] r);
        logic [31:0] q;
        q = 0;
        case (op)
            OP_OR:  q = l | r;
            OP_XOR: q = l ^ r;
            OP_AND: q = l & r;
            OP_EQ:  q = {31'd0, l == r};
            OP_NE:  q = {31'd0, l != r};
            OP_LT:  q = {31'd0, $signed(l) < $signed(r)};
            OP_GT:  q = {31'd0, $signed(l) > $signed(r)};
            OP_LE:  q = {31'd0, $signed(l) <= $signed(r)};
            OP_GE:  q = {31'd0, $signed(l) >= $signed(r)};
            OP_SHL: q = (r >= 32) ? 32'd0 : (l << r[4:0]);
            OP_SHR: q = (r >= 32) ? {32{l[31]}} : 32'($signed(l) >>> r[4:0]);
            OP_ADD: q = l + r;
            OP_SUB: q = l - r;
            OP_MUL: q = l * r;
            OP_DIV: begin
                q = mag(l) / mag(r);
                if (l[31] != r[31]) q = 32'd0 - q;
            end
            default: begin
                q = mag(l) % mag(r);
                if (l[31]) q = 32'd0 - q;
            end
        endcase
        return q;
    endfunction

    // true when the instruction touches only written memory and does not halt
    function automatic bit runs_clean(input logic [5:0] op);
        logic [31:0] a;
        if (vm_halted) return 0;
        if (op == OP_LEV)
            return is_written({16'd0, vm_fp}) && is_written({16'd0, vm_fp + 16'd4});
        if (op == OP_LI || op == OP_LC) return is_written(vm_acc);
        if (op == OP_SI) return is_written({16'd0, vm_sp});
        if (op == OP_SC) begin
            if (!is_written({16'd0, vm_sp})) return 0;
            a = mem_rd({16'd0, vm_sp});
            return is_written(a);
        end
        if (op == OP_DIV || op == OP_MOD) return vm_acc != 0 && is_written({16'd0, vm_sp});
        if (op >= OP_OR && op <= OP_MOD) return is_written({16'd0, vm_sp});
        return op <= OP_PUSH;
    endfunction

    task automatic exec_instr(input logic [5:0] op, input logic [31:0] imm,
                              output vm_state_out_t r);
        logic [13:0] pc;
        logic [31:0] t, a;
        logic [1:0]  st;
        logic [31:0] ex;
        pc = vm_pc;
        st = ST_RUN;
        ex = 0;
        if (vm_halted) begin
            st = vm_code;
            if (vm_code == ST_EXITED) ex = mem_rd({16'd0, vm_sp});
        end else if (op >= OP_OR && op <= OP_MOD) begin
            if ((op == OP_DIV || op == OP_MOD) && vm_acc == 0) begin
                st = ST_DIVZERO;
                vm_halted = 1;
                vm_code = ST_DIVZERO;
            end else begin
                pop_word(t);
                vm_acc = alu_calc(op, t, vm_acc);
                pc = pc + 14'd1;
            end
        end else begin
            case (op)
                OP_LEA: begin vm_acc = {16'd0, vm_fp} + imm * 4; pc = pc + 14'd2; end
                OP_IMM: begin vm_acc = imm; pc = pc + 14'd2; end
                OP_JMP: pc = imm[13:0];
                OP_CALL: begin
                    push_word({18'd0, pc + 14'd2});
                    pc = imm[13:0];
                end
                OP_JZ:  pc = (vm_acc != 0) ? pc + 14'd2 : imm[13:0];
                OP_JNZ: pc = (vm_acc != 0) ? imm[13:0] : pc + 14'd2;
                OP_ENT: begin
                    push_word({16'd0, vm_fp});
                    vm_fp = vm_sp;
                    vm_sp = vm_sp - 16'(imm * 4);
                    pc = pc + 14'd2;
                end
                OP_ADJ: begin vm_sp = vm_sp + 16'(imm * 4); pc = pc + 14'd2; end
                OP_LEV: begin
                    vm_sp = vm_fp;
                    pop_word(t);
                    vm_fp = t[15:0];
                    pop_word(t);
                    pc = t[13:0];
                end
                OP_LI: begin vm_acc = mem_rd(vm_acc); pc = pc + 14'd1; end
                OP_LC: begin
                    vm_acc = sext8(mem_rd(vm_acc) >> (vm_acc[1:0] * 8));
                    pc = pc + 14'd1;
                end
                OP_SI: begin pop_word(a); mem_wr(a, vm_acc); pc = pc + 14'd1; end
                OP_SC: begin
                    pop_word(a);
                    t = mem_rd(a);
                    t = t & ~(32'hFF << (a[1:0] * 8));
                    t = t | ((vm_acc & 32'hFF) << (a[1:0] * 8));
                    mem_wr(a, t);
                    vm_acc = sext8(vm_acc);
                    pc = pc + 14'd1;
                end
                OP_PUSH: begin push_word(vm_acc); pc = pc + 14'd1; end
                OP_EXIT: begin
                    ex = mem_rd({16'd0, vm_sp});
                    st = ST_EXITED;
                    vm_halted = 1;
                    vm_code = ST_EXITED;
                    pc = pc + 14'd1;
                end
                default: begin
                    st = ST_BADOP;
                    vm_halted = 1;
                    vm_code = ST_BADOP;
                end
            endcase
        end
        vm_pc = pc;
        r = '{pc: vm_pc, acc: vm_acc, sp: vm_sp, status: st, exitv: ex};
    endtask

    // queue one instruction; unless raw is set, one that would read unwritten memory or halt becomes a push
    task automatic issue(input logic [5:0] op, input logic [31:0] imm, input bit raw = 0);
        vm_state_out_t r;
        if (!raw && !runs_clean(op)) op = OP_PUSH;
        exec_instr(op, imm, r);
        pending_instrs.push_back('{op: op, imm: imm});
        expected_states.push_back(r);
    endtask

    function automatic logic [31:0] edge_value();
        case ($urandom_range(9))
            0: return 0;
            1: return 1;
            2: return 32'hFFFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            5: return $urandom_range(40);
            default: return $urandom;
        endcase
    endfunction

    // byte address of a written word, with random upper bits and byte lane
    function automatic logic [31:0] known_addr();
        int w;
        w = written_words[$urandom_range(written_words.size() - 1)];
        return {16'($urandom), w[13:0], 2'($urandom)};
    endfunction

    task automatic random_sequence();
        int n;
        case ($urandom_range(9))
            0, 1: begin
                issue(OP_IMM, edge_value());
                issue(OP_PUSH, 0);
                issue(OP_IMM, edge_value());
                issue(6'($urandom_range(OP_OR, OP_MOD)), 0);
            end
            2: begin
                if (written_words.size() > 0) begin
                    issue(OP_IMM, known_addr());
                    issue($urandom_range(1) ? OP_LI : OP_LC, 0);
                end
            end
            3: begin
                if ($urandom_range(1) || written_words.size() == 0)
                    issue(OP_IMM, $urandom);
                else
                    issue(OP_IMM, known_addr());
                issue(OP_PUSH, 0);
                issue(OP_IMM, edge_value());
                issue($urandom_range(1) ? OP_SI : OP_SC, 0);
            end
            4, 5: begin
                issue(OP_CALL, $urandom);
                issue(OP_ENT, $urandom_range(4));
                n = $urandom_range(3);
                repeat (n) begin
                    issue(OP_LEA, 32'($signed($urandom_range(6)) - 3));
                    issue(OP_PUSH, 0);
                end
                if ($urandom_range(1)) issue(OP_ADJ, n);
                issue(OP_LEV, 0);
            end
            6: begin
                issue(OP_IMM, $urandom_range(1) ? 32'd0 : edge_value());
                issue(6'($urandom_range(OP_JMP, OP_JNZ)), $urandom);
            end
            7: issue($urandom_range(1) ? OP_LEA : OP_ADJ, 32'($signed($urandom_range(16)) - 8));
            default: issue(6'($urandom_range(OP_MOD)), $urandom);
        endcase
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_START_PC) begin
            vm_start_pc = v[13:0];
            vm_pc = vm_start_pc;
        end else begin
            vm_stack_top = v[15:0];
            vm_sp = vm_stack_top;
            vm_fp = vm_stack_top;
        end
    endtask

    task automatic drain();
        wait (pending_instrs.size() == 0 && expected_states.size() == 0);
        repeat (50) @(posedge aclk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h, expected %h", what, got, want);
        errors++;
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_instrs.size() > 0 && $urandom_range(99) >= s_idle_pct) begin
                instr_t it;
                it = pending_instrs.pop_front();
                s_valid     <= 1'b1;
                s_operation <= it.op;
                s_immediate <= it.imm;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off on request
    always @(posedge aclk) begin
        if (hold_req && !hold_seen) begin
            hold_seen <= 1;
            hold_cnt  <= 400;
            m_ready   <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_states.size() == 0) begin
                report_mismatch("unexpected result", 32'(m_next_pc), 32'd0);
            end else begin
                vm_state_out_t e;
                e = expected_states.pop_front();
                if (m_next_pc != e.pc) report_mismatch("next_pc", 32'(m_next_pc), 32'(e.pc));
                if (m_acc_value != e.acc) report_mismatch("acc_value", m_acc_value, e.acc);
                if (m_stack_addr != e.sp) report_mismatch("stack_addr", 32'(m_stack_addr), 32'(e.sp));
                if (m_status != e.status) report_mismatch("status", 32'(m_status), 32'(e.status));
                if (m_exit_value != e.exitv) report_mismatch("exit_value", m_exit_value, e.exitv);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("** stack_bytecode_executor: FAILED **");
            $finish;
        end
    end

    initial begin
        vm_start_pc = START_PC_RST;
        vm_stack_top = STACK_TOP_RST;
        vm_pc = vm_start_pc;
        vm_sp = vm_stack_top;
        vm_fp = vm_stack_top;
        vm_acc = 0;
        vm_halted = 0;
        vm_code = ST_RUN;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: arithmetic extremes, shifts, division corners, char access, jumps, frames
        s_idle_pct = 15;
        m_idle_pct = 59;
        issue(OP_IMM, 32'h7FFF_FFFF);
        issue(OP_PUSH, 0);
        issue(OP_IMM, 32'h8000_0000);
        issue(OP_PUSH, 0);
        issue(OP_IMM, 32'hFFFF_FFFF);
        issue(OP_DIV, 0);
        issue(OP_PUSH, 0);
        issue(OP_IMM, 32'hFFFF_FFFF);
        issue(OP_MOD, 0);
        issue(OP_IMM, 32);
        issue(OP_SHR, 0);
        issue(OP_PUSH, 0);
        issue(OP_IMM, 31);
        issue(OP_SHL, 0);
        issue(OP_IMM, {16'hABCD, vm_sp + 16'd1});
        issue(OP_PUSH, 0);
        issue(OP_IMM, 32'h0000_0080);
        issue(OP_SC, 0);
        issue(OP_IMM, {16'h1234, vm_sp - 16'd3});
        issue(OP_LC, 0);
        issue(OP_JZ, 32'hFFFF_C005);
        issue(OP_JNZ, 7);
        issue(OP_CALL, 32'h7FFF_FFFF);
        issue(OP_ENT, 2);
        issue(OP_LEA, 32'hFFFF_FFFE);
        issue(OP_LEV, 0);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                1: begin
                    cfg_write(REG_START_PC, 32'h3FFF);
                    cfg_write(REG_STACK_TOP, 32'h0);
                    s_idle_pct = 59;
                    m_idle_pct = 15;
                end
                2: begin
                    cfg_write(REG_STACK_TOP, 32'hFFFF);
                    cfg_write(REG_START_PC, 32'h0);
                    s_idle_pct = 0;
                    m_idle_pct = 0;
                    hold_req = 1;
                end
                3: begin
                    cfg_write(REG_START_PC, $urandom);
                    cfg_write(REG_STACK_TOP, $urandom);
                end
                default: ;
            endcase
            while (expected_states.size() < 300) random_sequence();
            drain();
        end

        // one halting instruction, then some requests that a halted machine ignores
        case ($urandom_range(2))
            0: begin issue(OP_PUSH, 0); issue(OP_EXIT, $urandom, 1); end
            1: begin issue(OP_IMM, 0); issue($urandom_range(1) ? OP_DIV : OP_MOD, 0, 1); end
            default: issue($urandom_range(1) ? 6'($urandom_range(30, 36))
                                             : 6'($urandom_range(38, 63)), $urandom, 1);
        endcase
        repeat (8) issue(6'($urandom), $urandom, 1);
        drain();

        if (errors == 0)
            $display("** stack_bytecode_executor: PASSED **");
        else
            $display("** stack_bytecode_executor: FAILED **");
        $finish;
    end
endmodule
